// ----- src/htx_pkg.sv -----
// htx_pkg: shared types and constants for the HTML text extractor.
// Depends on nothing; imported by every module of the block.
package htx_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } htx_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_end;
  } htx_out_t;

  // Words produced by one input byte: zero, one or two.
  typedef struct packed {
    logic [1:0] count;
    htx_out_t   res0;
    htx_out_t   res1;
  } htx_res_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Window patterns, newest byte in the low bits.
  localparam logic [63:0] PAT_CLOSE_SCRIPT = "</script";
  localparam logic [55:0] PAT_CLOSE_STYLE  = "</style";
  localparam logic [47:0] PAT_OPEN_SCRIPT  = "<scrip";
  localparam logic [39:0] PAT_OPEN_STYLE   = "<styl";

endpackage

// ----- src/html_text_extractor_core.sv -----
// html_text_extractor_core: top level of the HTML text extractor.
// Instantiates htx_scan and htx_outq; uses htx_pkg.
//
// Usage:
//   in_*  : valid/ready channel of HTML bytes (htx_in_t), end_of_text marks
//           the final byte of a document.
//   out_* : valid/ready channel of extracted words (htx_out_t). A byte outside
//           tags and script/style elements goes out as is; whitespace runs
//           become one space, dropped at the start and end of the text.
//           An end byte with nothing to send yields a bare end marker.
//   Results are written into the registered result queue; out_* is driven from it.
//   Throughput: one byte per cycle while in_ready is high. A byte that releases
//           a pending space makes two words, which the output side sends one by one.
//   The scan decision is one pass over the flags and an eight-byte window;
//   the four-entry result queue sets the stall behavior: in_ready drops while
//   it holds more than two words, so a stalled receiver backs up the input
//   once the queue fills and nothing is lost.
//   Reset (rst_n low, synchronous) empties the queue and clears all flags and
//   the window; the end of a document does the same to the scan state.
module html_text_extractor_core
  import htx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  htx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output htx_out_t out_data
);

  logic     acc;
  htx_res_t res;

  assign acc = in_valid && in_ready;

  htx_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .res     (res)
  );

  htx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .res       (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/htx_scan.sv -----
// htx_scan: per-byte tag/hidden-element tracking and whitespace collapse.
// Holds the eight-byte window and the flags; uses htx_pkg.
module htx_scan
  import htx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  htx_in_t  in_data,
  output htx_res_t res
);

  logic [63:0] win_r, win_nxt;
  logic tag_r, tag_nxt;
  logic scr_r, scr_nxt;
  logic sty_r, sty_nxt;
  logic sp_r, sp_nxt;
  logic st_r, st_nxt;

  logic [7:0] c;
  logic       is_space;

  assign c        = in_data.text_byte;
  assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);

  always_comb begin
    tag_nxt = tag_r;
    scr_nxt = scr_r;
    sty_nxt = sty_r;
    sp_nxt  = sp_r;
    st_nxt  = st_r;
    win_nxt = {win_r[55:0], c};
    res     = '0;

    priority if (c == CH_LT) begin
      tag_nxt = 1'b1;
    end else if (c == CH_GT) begin
      tag_nxt = 1'b0;
      priority if (win_r == PAT_CLOSE_SCRIPT) begin
        scr_nxt = 1'b0;
      end else if (win_r[55:0] == PAT_CLOSE_STYLE) begin
        sty_nxt = 1'b0;
      end else begin
      end
    end else begin
      priority if (c == CH_T && win_r[47:0] == PAT_OPEN_SCRIPT) begin
        scr_nxt = 1'b1;
      end else if (c == CH_E && win_r[39:0] == PAT_OPEN_STYLE) begin
        sty_nxt = 1'b1;
      end else begin
      end
      if (!tag_r && !scr_nxt && !sty_nxt) begin
        if (is_space) begin
          if (st_r) begin
            sp_nxt = 1'b1;
          end
        end else begin
          st_nxt = 1'b1;
          sp_nxt = 1'b0;
          if (sp_r) begin
            res.count = 2'd2;
            res.res0  = '{out_byte: CH_SPACE, byte_valid: 1'b1, out_end: 1'b0};
            res.res1  = '{out_byte: c, byte_valid: 1'b1, out_end: 1'b0};
          end else begin
            res.count = 2'd1;
            res.res0  = '{out_byte: c, byte_valid: 1'b1, out_end: 1'b0};
          end
        end
      end
    end

    if (in_data.end_of_text) begin
      unique case (res.count)
        2'd0: begin
          res.count = 2'd1;
          res.res0  = '{out_byte: 8'h00, byte_valid: 1'b0, out_end: 1'b1};
        end
        2'd1:    res.res0.out_end = 1'b1;
        default: res.res1.out_end = 1'b1;
      endcase
      tag_nxt = 1'b0;
      scr_nxt = 1'b0;
      sty_nxt = 1'b0;
      sp_nxt  = 1'b0;
      st_nxt  = 1'b0;
      win_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      tag_r <= 1'b0;
      scr_r <= 1'b0;
      sty_r <= 1'b0;
      sp_r  <= 1'b0;
      st_r  <= 1'b0;
    end else if (acc) begin
      win_r <= win_nxt;
      tag_r <= tag_nxt;
      scr_r <= scr_nxt;
      sty_r <= sty_nxt;
      sp_r  <= sp_nxt;
      st_r  <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.end_of_text |-> res.count != 2'd0)
    else $error("end byte produced no word");

  a_pair_is_space: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.count == 2'd2 |-> res.res0.out_byte == CH_SPACE && st_r)
    else $error("two-word result without leading collapsed space");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.end_of_text |=> win_r == '0 && !tag_r && !sp_r && !st_r)
    else $error("state not cleared after end of text");
`endif

endmodule

// ----- src/htx_outq.sv -----
// htx_outq: small result queue, up to two words written per cycle, one read.
// Separates the scan logic from the output handshake; uses htx_pkg.
module htx_outq
  import htx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  htx_res_t res,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output htx_out_t out_data
);

  htx_out_t mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic [1:0]     n_push;
  logic           pop;

  assign n_push    = push ? res.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  // keep space for a full two-word item regardless of this cycle's pop
  assign room      = (cnt_r <= QCW'(QDEPTH - 2));
  assign cnt_nxt   = cnt_r + QCW'(n_push) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wp_r] <= res.res0;
    end
    if (n_push == 2'd2) begin
      mem_r[wp_r + QAW'(1)] <= res.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QAW'(n_push);
      rp_r  <= rp_r + QAW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room)
    else $error("push without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && n_push == 2'd0 |=> cnt_r == $past(cnt_r) - QCW'(1))
    else $error("pop did not drain queue");
`endif

endmodule

// ----- tb/sv/html_text_extractor_core_tb.sv -----
// Testbench for html_text_extractor_core: directed and random HTML documents,
// a scoreboard class that predicts the extracted words, and randomized flow control.
// Depends on htx_pkg and the html_text_extractor_core RTL.
module html_text_extractor_core_tb
  import htx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 500;
  localparam int DRAIN_LIMIT    = 20000;

  // Window patterns, newest byte in the low bits.
  localparam logic [63:0] SEQ_CLOSE_SCRIPT = "</script";
  localparam logic [55:0] SEQ_CLOSE_STYLE  = "</style";
  localparam logic [47:0] SEQ_OPEN_SCRIPT  = "<scrip";
  localparam logic [39:0] SEQ_OPEN_STYLE   = "<styl";

  class htx_scoreboard;
    logic [63:0] window;
    bit          in_tag;
    bit          hid_script;
    bit          hid_style;
    bit          space_pend;
    bit          started;
    htx_out_t    expected_words[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      window     = '0;
      in_tag     = 1'b0;
      hid_script = 1'b0;
      hid_style  = 1'b0;
      space_pend = 1'b0;
      started    = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Predict the words caused by one accepted input word; returns their count.
    function int note_byte(htx_in_t w);
      htx_out_t    words [0:1];
      int          n;
      logic [7:0]  c;
      n = 0;
      c = w.text_byte;
      if (c == CH_LT) begin
        in_tag = 1'b1;
      end else if (c == CH_GT) begin
        in_tag = 1'b0;
        if (window == SEQ_CLOSE_SCRIPT) hid_script = 1'b0;
        else if (window[55:0] == SEQ_CLOSE_STYLE) hid_style = 1'b0;
      end else begin
        if (c == CH_T && window[47:0] == SEQ_OPEN_SCRIPT) hid_script = 1'b1;
        else if (c == CH_E && window[39:0] == SEQ_OPEN_STYLE) hid_style = 1'b1;
        if (!in_tag && !hid_script && !hid_style) begin
          if (is_blank(c)) begin
            if (started) space_pend = 1'b1;
          end else begin
            if (space_pend) begin
              words[n] = '{out_byte: CH_SPACE, byte_valid: 1'b1, out_end: 1'b0};
              n++;
              space_pend = 1'b0;
            end
            words[n] = '{out_byte: c, byte_valid: 1'b1, out_end: 1'b0};
            n++;
            started = 1'b1;
          end
        end
      end
      window = {window[55:0], c};
      if (w.end_of_text) begin
        if (n == 0) begin
          words[0] = '{out_byte: 8'h00, byte_valid: 1'b0, out_end: 1'b1};
          n = 1;
        end else begin
          words[n-1].out_end = 1'b1;
        end
        clear_state();
      end
      for (int i = 0; i < n; i++) expected_words.insert(expected_words.size(), words[i]);
      return n;
    endfunction

    function void mismatch(string field, int exp_val, int got_val);
      errors++;
      $error("%s: expected %0h, got %0h", field, exp_val, got_val);
    endfunction

    function void check_word(htx_out_t got);
      htx_out_t exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        $error("unexpected word: out_byte %0h byte_valid %0b out_end %0b",
               got.out_byte, got.byte_valid, got.out_end);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.out_byte !== exp_w.out_byte)
        mismatch("out_byte", exp_w.out_byte, got.out_byte);
      if (got.byte_valid !== exp_w.byte_valid)
        mismatch("byte_valid", exp_w.byte_valid, got.byte_valid);
      if (got.out_end !== exp_w.out_end)
        mismatch("out_end", exp_w.out_end, got.out_end);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  htx_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  htx_out_t out_data;

  htx_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int phase_items = 0;
  int cycle_count = 0;
  logic [7:0] doc_bytes[$];

  html_text_extractor_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("html_text_extractor_core test failed");
      $finish;
    end
  end

  // Result side: check accepted words, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_byte(logic [7:0] b, bit last);
    htx_in_t w;
    w.text_byte = b;
    w.end_of_text = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(sb.note_byte(w));
    phase_items++;
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_bytes.size(); i++)
      send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  function void add_byte(logic [7:0] b);
    doc_bytes.insert(doc_bytes.size(), b);
  endfunction

  function void push_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(9) == 0) return 8'($urandom_range(255, 128));
    c = 8'($urandom_range(126, 33));
    if (c == CH_LT || c == CH_GT) c = "q";
    return c;
  endfunction

  function void push_word();
    int len;
    len = $urandom_range(6, 1);
    repeat (len) add_byte(text_char());
  endfunction

  function void push_blanks();
    int len;
    len = $urandom_range(3, 1);
    repeat (len) begin
      if ($urandom_range(1)) add_byte(CH_SPACE);
      else add_byte(8'($urandom_range(CH_CR, CH_TAB)));
    end
  endfunction

  // Hidden element body: text, blanks and the odd nested tag.
  function void push_body();
    int parts;
    parts = $urandom_range(3);
    repeat (parts) begin
      case ($urandom_range(3))
        0: push_word();
        1: push_blanks();
        2: push_str("<b>");
        default: push_str("x<y");
      endcase
    end
  endfunction

  function void build_random_doc();
    int frags;
    int pick;
    doc_bytes.delete();
    frags = $urandom_range(12, 1);
    repeat (frags) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_word();
      end else if (pick < 50) begin
        push_blanks();
      end else if (pick < 62) begin
        case ($urandom_range(5))
          0: push_str("<p>");
          1: push_str("</p>");
          2: push_str("<div class=a>");
          3: push_str("<br/>");
          4: push_str("<a href=\"s\">");
          default: push_str("</b>");
        endcase
      end else if (pick < 72) begin
        if ($urandom_range(1)) push_str("<script>");
        else push_str("<script src=j>");
        push_body();
        push_str("</script>");
      end else if (pick < 80) begin
        if ($urandom_range(1)) push_str("<style>");
        else push_str("<style type=t>");
        push_body();
        push_str("</style>");
      end else if (pick < 90) begin
        // near misses, stray closers and unterminated openers
        case ($urandom_range(8))
          0: push_str("<scrip>");
          1: push_str("</scrip>");
          2: push_str("<SCRIPT>");
          3: push_str("<scripts>");
          4: push_str("</style");
          5: push_str("<styl e>");
          6: push_str("script>");
          7: push_str("</script>");
          default: push_str("<style");
        endcase
      end else begin
        repeat ($urandom_range(4, 1)) add_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Leading blanks, collapse before a high byte, tag, zero byte, trailing blank at end.
    doc_bytes = '{CH_SPACE, CH_TAB, "A", CH_SPACE, CH_CR, 8'hFF, CH_LT, 8'h80, CH_GT,
                  8'h00, CH_SPACE};
    send_doc();
    doc_bytes = '{"z"};
    send_doc();
    doc_bytes = '{CH_GT};
    send_doc();
    doc_bytes = '{8'h7F, CH_SPACE, 8'h0B};
    send_doc();
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // long receiver hold while the sender keeps offering
      if (phase == 0 || phase == 3) hold_requests++;
      phase_items = 0;
      while (phase_items < PHASE_BYTES) begin
        build_random_doc();
        send_doc();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("html_text_extractor_core test passed");
    end else begin
      $display("html_text_extractor_core test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/htx_pkg.sv
src/htx_scan.sv
src/htx_outq.sv
src/html_text_extractor_core.sv
tb/sv/html_text_extractor_core_tb.sv
